@@ rtl/lsula_pkg.sv @@
// shared types, codes and constants of the load/store lane align unit
package lsula_pkg;

  localparam int unsigned AddrW    = 32;
  localparam int unsigned DataW    = 32;
  localparam int unsigned TagW     = 4;
  localparam int unsigned RegW     = 5;
  localparam int unsigned BeW      = 4;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned TagBitsDefault = 4;

  localparam logic CmdReq = 1'b0;
  localparam logic CmdRsp = 1'b1;

  localparam logic [1:0] SizeByte    = 2'd0;
  localparam logic [1:0] SizeHalf    = 2'd1;
  localparam logic [1:0] SizeWord    = 2'd2;
  localparam logic [1:0] SizeWordAlt = 2'd3;

  localparam logic [CfgIdxW-1:0] CfgDataBase  = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgDataSize  = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgInstrBase = 2'd2;
  localparam logic [CfgIdxW-1:0] CfgInstrSize = 2'd3;

  typedef enum logic [1:0] {
    KindIssue = 2'd0,
    KindDone  = 2'd1,
    KindBusy  = 2'd2,
    KindDrop  = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    TargetData  = 2'd0,
    TargetInstr = 2'd1,
    TargetBus   = 2'd2
  } target_e;

  typedef enum logic [1:0] {
    ErrNone       = 2'd0,
    ErrMisaligned = 2'd1,
    ErrBus        = 2'd2
  } error_e;

  typedef struct packed {
    logic             command;
    logic [AddrW-1:0] addr;
    logic             is_load;
    logic [1:0]       size_code;
    logic             zero_ext;
    logic [DataW-1:0] st_value;
    logic             want_wb;
    logic [RegW-1:0]  dest_reg;
    logic [TagW-1:0]  tag;
    logic [DataW-1:0] read_lane;
    logic             bus_error;
  } in_item_t;

  typedef struct packed {
    kind_e            kind;
    target_e          target;
    logic [AddrW-1:0] mem_addr;
    logic             mem_write;
    logic [BeW-1:0]   lane_strobe;
    logic [DataW-1:0] write_lane;
    logic [TagW-1:0]  done_tag;
    logic [RegW-1:0]  done_dest_reg;
    logic             write_back;
    logic [DataW-1:0] load_result;
    error_e           error;
    logic [AddrW-1:0] bad_addr;
  } out_item_t;

  typedef struct packed {
    logic [AddrW-1:0] addr;
    logic [1:0]       size;
    logic             zero_ext;
    logic             is_load;
    logic             want_wb;
    logic [RegW-1:0]  dest_reg;
  } held_t;

  typedef struct packed {
    logic [AddrW-1:0] data_base;
    logic [AddrW-1:0] data_size;
    logic [AddrW-1:0] instr_base;
    logic [AddrW-1:0] instr_size;
  } cfg_t;

  typedef struct packed {
    logic             misaligned;
    logic [1:0]       size;
    target_e          target;
    logic [BeW-1:0]   lane_strobe;
    logic [DataW-1:0] write_lane;
  } issue_t;

endpackage

@@ rtl/lsula_beat_if.sv @@
// valid/ready channel carrying one payload beat
interface lsula_beat_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
  modport monitor (input valid, input payload, input ready);
endinterface

@@ rtl/load_store_unit_lane_align.sv @@
// top level of the load/store unit lane align block
//
//   channel   dir   handshake        payload
//   in_i      in    valid/ready      in_item_t (request or response beat)
//   out_o     out   valid/ready      out_item_t (one result beat per input)
//   cfg       in    cfg_we_i         cfg_idx_i, cfg_wdata_i (region base/size)
//
// one beat per cycle while out_o is not stalled; beats pass in_q, then out_q
// the input register feeds decode logic whose result and unit state update together
// a beat moves forward when the result register is empty or being taken
// reset clears valid flags, busy flag and region registers; no clearing pass
module load_store_unit_lane_align
  import lsula_pkg::*;
#(
  parameter int unsigned TagBits = TagBitsDefault
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  lsula_beat_if.sink         in_i,
  lsula_beat_if.source       out_o,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [AddrW-1:0]   cfg_wdata_i
);

  localparam int unsigned HeldTagBits = (TagBits < TagW) ? TagBits : TagW;

  in_item_t               in_q;
  logic                   in_vld_q;
  out_item_t              out_q;
  out_item_t              res;
  logic                   out_vld_q;
  logic                   busy_q;
  held_t                  held_q;
  logic [HeldTagBits-1:0] held_tag_q;
  logic [HeldTagBits-1:0] in_tag;
  cfg_t                   cfg_q;
  issue_t                 issue;
  logic [DataW-1:0]       load_result;
  logic                   adv;

  assign adv        = in_vld_q && (!out_vld_q || out_o.ready);
  assign in_i.ready = !in_vld_q || adv;
  assign out_o.valid   = out_vld_q;
  assign out_o.payload = out_q;
  assign in_tag = in_q.tag[HeldTagBits-1:0];

  lsula_req u_req (
    .addr_i      (in_q.addr),
    .size_code_i (in_q.size_code),
    .st_value_i  (in_q.st_value),
    .cfg_i       (cfg_q),
    .issue_o     (issue)
  );

  lsula_rsp u_rsp (
    .held_i        (held_q),
    .read_lane_i   (in_q.read_lane),
    .bus_error_i   (in_q.bus_error),
    .load_result_o (load_result)
  );

  always_comb begin
    res = '0;
    if (in_q.command == CmdReq) begin
      if (busy_q) begin
        res.kind = KindBusy;
      end else if (issue.misaligned) begin
        res.kind          = KindDone;
        res.done_tag      = TagW'(in_tag);
        res.done_dest_reg = in_q.dest_reg;
        res.error         = ErrMisaligned;
        res.bad_addr      = in_q.addr;
      end else begin
        res.kind        = KindIssue;
        res.target      = issue.target;
        res.mem_addr    = in_q.addr;
        res.mem_write   = !in_q.is_load;
        res.lane_strobe = in_q.is_load ? '0 : issue.lane_strobe;
        res.write_lane  = in_q.is_load ? '0 : issue.write_lane;
      end
    end else if (!busy_q) begin
      res.kind = KindDrop;
    end else begin
      res.kind          = KindDone;
      res.done_tag      = TagW'(held_tag_q);
      res.done_dest_reg = held_q.dest_reg;
      res.write_back    = held_q.want_wb && held_q.is_load;
      res.load_result   = load_result;
      if (in_q.bus_error) begin
        res.error    = ErrBus;
        res.bad_addr = held_q.addr;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
      busy_q    <= 1'b0;
    end else begin
      if (in_i.valid && in_i.ready) begin
        in_vld_q <= 1'b1;
      end else if (adv) begin
        in_vld_q <= 1'b0;
      end
      if (adv) begin
        out_vld_q <= 1'b1;
      end else if (out_o.ready) begin
        out_vld_q <= 1'b0;
      end
      if (adv) begin
        if (in_q.command == CmdReq) begin
          if (!busy_q && !issue.misaligned) begin
            busy_q <= 1'b1;
          end
        end else begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgDataBase:  cfg_q.data_base  <= cfg_wdata_i;
        CfgDataSize:  cfg_q.data_size  <= cfg_wdata_i;
        CfgInstrBase: cfg_q.instr_base <= cfg_wdata_i;
        CfgInstrSize: cfg_q.instr_size <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      in_q <= in_i.payload;
    end
    if (adv) begin
      out_q <= res;
    end
    if (adv && (in_q.command == CmdReq) && !busy_q && !issue.misaligned) begin
      held_q.addr     <= in_q.addr;
      held_q.size     <= issue.size;
      held_q.zero_ext <= in_q.zero_ext;
      held_q.is_load  <= in_q.is_load;
      held_q.want_wb  <= in_q.want_wb;
      held_q.dest_reg <= in_q.dest_reg;
      held_tag_q      <= in_tag;
    end
  end

endmodule

@@ rtl/lsula_req.sv @@
// request decode: alignment check, region select, lane replication, byte enables
module lsula_req
  import lsula_pkg::*;
(
  input  logic [AddrW-1:0] addr_i,
  input  logic [1:0]       size_code_i,
  input  logic [DataW-1:0] st_value_i,
  input  cfg_t             cfg_i,
  output issue_t           issue_o
);

  logic [1:0]       size;
  logic [AddrW-1:0] data_off;
  logic [AddrW-1:0] instr_off;
  logic             hit_data;
  logic             hit_instr;

  assign size = (size_code_i == SizeWordAlt) ? SizeWord : size_code_i;

  assign data_off  = addr_i - cfg_i.data_base;
  assign instr_off = addr_i - cfg_i.instr_base;
  assign hit_data  = (addr_i >= cfg_i.data_base) && (data_off < cfg_i.data_size);
  assign hit_instr = (addr_i >= cfg_i.instr_base) && (instr_off < cfg_i.instr_size);

  always_comb begin
    issue_o = '0;
    issue_o.size = size;
    issue_o.misaligned = ((size == SizeHalf) && addr_i[0]) ||
                         ((size == SizeWord) && (addr_i[1:0] != 2'b00));
    priority if (hit_data) begin
      issue_o.target = TargetData;
    end else if (hit_instr) begin
      issue_o.target = TargetInstr;
    end else begin
      issue_o.target = TargetBus;
    end
    unique case (size)
      SizeByte: begin
        issue_o.write_lane  = {4{st_value_i[7:0]}};
        issue_o.lane_strobe = BeW'(1) << addr_i[1:0];
      end
      SizeHalf: begin
        issue_o.write_lane  = {2{st_value_i[15:0]}};
        issue_o.lane_strobe = addr_i[1] ? 4'b1100 : 4'b0011;
      end
      default: begin
        issue_o.write_lane  = st_value_i;
        issue_o.lane_strobe = 4'b1111;
      end
    endcase
  end

endmodule

@@ rtl/lsula_rsp.sv @@
// response lane extraction: shift, mask and sign or zero extension
module lsula_rsp
  import lsula_pkg::*;
(
  input  held_t            held_i,
  input  logic [DataW-1:0] read_lane_i,
  input  logic             bus_error_i,
  output logic [DataW-1:0] load_result_o
);

  logic [DataW-1:0] shifted;
  logic             ext;

  assign shifted = read_lane_i >> {held_i.addr[1:0], 3'b000};

  always_comb begin
    load_result_o = '0;
    ext = 1'b0;
    if (held_i.is_load && !bus_error_i) begin
      unique case (held_i.size)
        SizeByte: begin
          ext = !held_i.zero_ext && shifted[7];
          load_result_o = {{24{ext}}, shifted[7:0]};
        end
        SizeHalf: begin
          ext = !held_i.zero_ext && shifted[15];
          load_result_o = {{16{ext}}, shifted[15:0]};
        end
        default: begin
          load_result_o = read_lane_i;
        end
      endcase
    end
  end

endmodule

@@ rtl/lsula_checker.sv @@
// port-level checks of the lane align block and their bind to the top level
module lsula_checker
  import lsula_pkg::*;
(
  input logic      clk_i,
  input logic      rst_ni,
  input logic      in_valid_i,
  input logic      in_ready_i,
  input logic      out_valid_i,
  input logic      out_ready_i,
  input out_item_t out_beat_i
);

  a_out_hold_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !out_ready_i) |=> out_valid_i)
    else $error("result beat dropped while stalled");

  a_out_hold_payload: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !out_ready_i) |=> $stable(out_beat_i))
    else $error("result payload changed while stalled");

  a_progress: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_i) ##1 out_ready_i |=> out_valid_i)
    else $error("accepted beat produced no result");

  a_misaligned_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && (out_beat_i.error == ErrMisaligned)) |->
      (out_beat_i.kind == KindDone) && !out_beat_i.write_back &&
      (out_beat_i.load_result == '0))
    else $error("misaligned completion carries write-back or data");

  a_load_issue_lane: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && (out_beat_i.kind == KindIssue) && !out_beat_i.mem_write) |->
      (out_beat_i.lane_strobe == '0) && (out_beat_i.write_lane == '0))
    else $error("read access carries write lane or byte enables");

endmodule

bind load_store_unit_lane_align lsula_checker u_lsula_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_beat_i  (out_o.payload)
);

@@ dv/tb.sv @@
// self-checking testbench of the load/store unit lane align block
module tb;
  import lsula_pkg::*;

  localparam int unsigned CycleLimit     = 600000;
  localparam int unsigned MaxGap         = 14;
  localparam int unsigned SinkHoldCycles = 120;

  logic clk_i = 1'b0;
  logic rst_ni;
  logic               cfg_we_i;
  logic [CfgIdxW-1:0] cfg_idx_i;
  logic [AddrW-1:0]   cfg_wdata_i;

  lsula_beat_if #(.payload_t(in_item_t))  in_if ();
  lsula_beat_if #(.payload_t(out_item_t)) out_if ();

  load_store_unit_lane_align DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_if),
    .out_o       (out_if),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // region registers as last written, and the unit state of the predictor
  cfg_t             regions = '0;
  logic             unit_busy = 1'b0;
  logic [AddrW-1:0] pend_addr = '0;
  logic [1:0]       pend_size = SizeByte;
  logic             pend_zext = 1'b0;
  logic             pend_load = 1'b0;
  logic             pend_rdw = 1'b0;
  logic [RegW-1:0]  pend_dest = '0;
  logic [TagW-1:0]  pend_tag = '0;

  out_item_t   pending_results[$];
  int unsigned fault_count = 0;
  int unsigned cycle_count = 0;
  int unsigned beats_sent = 0;
  int unsigned region_settings = 0;
  int unsigned kind_seen[4] = '{0, 0, 0, 0};
  int unsigned target_seen[3] = '{0, 0, 0};
  int unsigned misaligned_seen = 0;
  int unsigned bus_err_seen = 0;
  bit          tx_gaps = 1'b1;
  bit          rx_stalls = 1'b1;
  logic        sink_hold;
  event        hold_sink_ev;

  function automatic bit in_rgn(logic [AddrW-1:0] a, logic [AddrW-1:0] base,
                                logic [AddrW-1:0] size);
    return (a >= base) && ((a - base) < size);
  endfunction

  function automatic out_item_t lane_align_result(input in_item_t beat);
    out_item_t  r;
    logic [1:0] sz;
    logic [DataW-1:0] shifted;
    r = '0;
    sz = (beat.size_code == SizeWordAlt) ? SizeWord : beat.size_code;
    if (beat.command == CmdReq) begin
      if (unit_busy) begin
        r.kind = KindBusy;
      end else if ((sz == SizeHalf && beat.addr[0]) ||
                   (sz == SizeWord && beat.addr[1:0] != 2'b00)) begin
        r.kind = KindDone;
        r.done_tag = beat.tag;
        r.done_dest_reg = beat.dest_reg;
        r.error = ErrMisaligned;
        r.bad_addr = beat.addr;
      end else begin
        r.kind = KindIssue;
        if (in_rgn(beat.addr, regions.data_base, regions.data_size)) r.target = TargetData;
        else if (in_rgn(beat.addr, regions.instr_base, regions.instr_size)) begin
          r.target = TargetInstr;
        end else r.target = TargetBus;
        r.mem_addr = beat.addr;
        r.mem_write = !beat.is_load;
        if (!beat.is_load) begin
          case (sz)
            SizeByte: begin
              r.write_lane = {4{beat.st_value[7:0]}};
              r.lane_strobe = 4'b0001 << beat.addr[1:0];
            end
            SizeHalf: begin
              r.write_lane = {2{beat.st_value[15:0]}};
              r.lane_strobe = beat.addr[1] ? 4'b1100 : 4'b0011;
            end
            default: begin
              r.write_lane = beat.st_value;
              r.lane_strobe = 4'b1111;
            end
          endcase
        end
        unit_busy = 1'b1;
        pend_addr = beat.addr;
        pend_size = sz;
        pend_zext = beat.zero_ext;
        pend_load = beat.is_load;
        pend_rdw = beat.want_wb;
        pend_dest = beat.dest_reg;
        pend_tag = beat.tag;
      end
    end else if (!unit_busy) begin
      r.kind = KindDrop;
    end else begin
      r.kind = KindDone;
      r.done_tag = pend_tag;
      r.done_dest_reg = pend_dest;
      r.write_back = pend_rdw && pend_load;
      if (beat.bus_error) begin
        r.error = ErrBus;
        r.bad_addr = pend_addr;
      end else if (pend_load) begin
        shifted = beat.read_lane >> {pend_addr[1:0], 3'b000};
        case (pend_size)
          SizeByte: r.load_result = pend_zext ? {24'd0, shifted[7:0]}
                                              : {{24{shifted[7]}}, shifted[7:0]};
          SizeHalf: r.load_result = pend_zext ? {16'd0, shifted[15:0]}
                                              : {{16{shifted[15]}}, shifted[15:0]};
          default:  r.load_result = beat.read_lane;
        endcase
      end
      unit_busy = 1'b0;
    end
    return r;
  endfunction

  function automatic in_item_t noise_beat();
    logic [127:0] raw;
    raw = {$urandom(), $urandom(), $urandom(), $urandom()};
    return raw[$bits(in_item_t)-1:0];
  endfunction

  function automatic in_item_t mk_req(logic [AddrW-1:0] addr, bit load, logic [1:0] sz);
    in_item_t beat;
    beat = noise_beat();
    beat.command = CmdReq;
    beat.addr = addr;
    beat.is_load = load;
    beat.size_code = sz;
    return beat;
  endfunction

  function automatic in_item_t mk_rsp(logic [DataW-1:0] lane, bit berr);
    in_item_t beat;
    beat = noise_beat();
    beat.command = CmdRsp;
    beat.read_lane = lane;
    beat.bus_error = berr;
    return beat;
  endfunction

  // addresses cluster on region edges and the ends of the address space
  function automatic logic [AddrW-1:0] pick_addr(logic [1:0] sz);
    logic [AddrW-1:0] a;
    logic [AddrW-1:0] jitter;
    jitter = 32'($urandom_range(0, 15)) - 32'd8;
    case ($urandom_range(0, 9))
      0: a = regions.data_base + jitter;
      1: a = regions.data_base + regions.data_size + jitter;
      2: a = regions.instr_base + jitter;
      3: a = regions.instr_base + regions.instr_size + jitter;
      4: a = 32'hffff_fff0 | 32'($urandom_range(0, 15));
      5: a = 32'($urandom_range(0, 15));
      default: a = $urandom();
    endcase
    if ($urandom_range(0, 9) != 0) begin
      if (sz == SizeHalf) a[0] = 1'b0;
      else if (sz != SizeByte) a[1:0] = 2'b00;
    end
    return a;
  endfunction

  function automatic bit field_diff(string name, logic [31:0] want_v, logic [31:0] got_v,
                                    bit loud);
    if (want_v === got_v) return 1'b0;
    if (loud) $display("  %s: expected %h got %h", name, want_v, got_v);
    return 1'b1;
  endfunction

  task automatic send_beat(input in_item_t beat);
    int unsigned gap;
    gap = tx_gaps ? $urandom_range(0, MaxGap) : 0;
    if (gap != 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_if.valid <= 1'b1;
    in_if.payload <= beat;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    beats_sent++;
  endtask

  task automatic wait_idle();
    in_if.valid <= 1'b0;
    @(posedge clk_i);
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [AddrW-1:0] value);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= value;
    @(posedge clk_i);
  endtask

  task automatic set_regions(input logic [AddrW-1:0] dbase, input logic [AddrW-1:0] dsize,
                             input logic [AddrW-1:0] ibase, input logic [AddrW-1:0] isize);
    write_reg(CfgDataBase, dbase);
    write_reg(CfgDataSize, dsize);
    write_reg(CfgInstrBase, ibase);
    write_reg(CfgInstrSize, isize);
    cfg_we_i <= 1'b0;
    regions.data_base = dbase;
    regions.data_size = dsize;
    regions.instr_base = ibase;
    regions.instr_size = isize;
    region_settings++;
    @(posedge clk_i);
  endtask

  // mostly request/response pairs, with refused requests and stray responses mixed in
  task automatic run_traffic(input int unsigned n_beats);
    int unsigned stop_at;
    logic [1:0]  sz;
    stop_at = beats_sent + n_beats;
    while (beats_sent < stop_at) begin
      sz = ($urandom_range(0, 9) == 0) ? SizeWordAlt : 2'($urandom_range(0, 2));
      send_beat(mk_req(pick_addr(sz), 1'($urandom_range(0, 1)), sz));
      if ($urandom_range(0, 9) == 0) send_beat(mk_req($urandom(), 1'($urandom_range(0, 1)), sz));
      if ($urandom_range(0, 19) != 0) send_beat(mk_rsp($urandom(), $urandom_range(0, 7) == 0));
      if ($urandom_range(0, 24) == 0) send_beat(mk_rsp($urandom(), 1'($urandom_range(0, 1))));
    end
  endtask

  task automatic test_directed();
    in_item_t beat;
    send_beat(mk_rsp(32'hdead_beef, 1'b0));
    beat = mk_req(32'hffff_ffff, 1'b0, SizeByte);
    beat.st_value = 32'h0000_00a5;
    send_beat(beat);
    send_beat(mk_rsp(32'h0, 1'b0));
    send_beat(mk_req(32'h0, 1'b1, SizeWord));
    send_beat(mk_req(32'h10, 1'b0, SizeByte));
    send_beat(mk_rsp(32'hffff_ffff, 1'b1));
    send_beat(mk_req(32'h1, 1'b1, SizeHalf));
    send_beat(mk_req(32'h2, 1'b0, SizeWord));
    send_beat(mk_req(32'h3, 1'b1, SizeWordAlt));
    beat = mk_req(32'h3, 1'b1, SizeByte);
    beat.zero_ext = 1'b0;
    beat.want_wb = 1'b1;
    beat.dest_reg = 5'd31;
    beat.tag = 4'hf;
    send_beat(beat);
    send_beat(mk_rsp(32'h80ff_0000, 1'b0));
    beat = mk_req(32'h2, 1'b1, SizeHalf);
    beat.zero_ext = 1'b0;
    send_beat(beat);
    send_beat(mk_rsp(32'h8001_7fff, 1'b0));
    beat = mk_req(32'h0, 1'b1, SizeHalf);
    beat.zero_ext = 1'b1;
    send_beat(beat);
    send_beat(mk_rsp(32'h0000_ffff, 1'b0));
    send_beat(mk_req(32'h4, 1'b1, SizeWordAlt));
    send_beat(mk_rsp(32'h1234_5678, 1'b0));
    beat = mk_req(32'h6, 1'b0, SizeHalf);
    beat.st_value = 32'hffff_8001;
    send_beat(beat);
    send_beat(mk_rsp(32'h0, 1'b1));
    send_beat(mk_req(32'h8, 1'b0, SizeWord));
    send_beat(mk_rsp(32'h0, 1'b0));
    send_beat(mk_rsp(32'h0, 1'b1));
    wait_idle();
  endtask

  task automatic test_regions();
    set_regions(32'h0000_1000, 32'h0000_1000, 32'h8000_0000, 32'h0001_0000);
    run_traffic(80);
    wait_idle();
    set_regions(32'h0000_0000, 32'hffff_ffff, 32'hffff_ff00, 32'h0000_0100);
    run_traffic(80);
    wait_idle();
    set_regions(32'hffff_ffff, 32'hffff_ffff, 32'h0000_0000, 32'h0000_0000);
    run_traffic(80);
    wait_idle();
    set_regions(32'h1000_0800, 32'h0000_0100, 32'h1000_0000, 32'h1000_0000);
    run_traffic(80);
    wait_idle();
  endtask

  task automatic test_random();
    logic [AddrW-1:0] sizes[4];
    for (int phase = 0; phase < 4; phase++) begin
      for (int k = 0; k < 4; k++) begin
        case ($urandom_range(0, 3))
          0: sizes[k] = 32'h0;
          1: sizes[k] = 32'($urandom_range(1, 4096));
          2: sizes[k] = $urandom();
          default: sizes[k] = 32'hffff_ffff;
        endcase
      end
      set_regions($urandom(), sizes[1], $urandom(), sizes[3]);
      tx_gaps = (phase % 2) == 0;
      rx_stalls = phase < 2;
      run_traffic(300);
      wait_idle();
    end
    tx_gaps = 1'b1;
    rx_stalls = 1'b1;
  endtask

  task automatic test_backpressure();
    tx_gaps = 1'b0;
    rx_stalls = 1'b0;
    -> hold_sink_ev;
    run_traffic(40);
    wait_idle();
    tx_gaps = 1'b1;
    rx_stalls = 1'b1;
  endtask

  // expectations are formed at the edge where an input beat is taken
  always @(posedge clk_i) begin
    if (rst_ni && in_if.valid && in_if.ready) begin
      pending_results.push_back(lane_align_result(in_if.payload));
    end
  end

  always @(posedge clk_i) begin : result_check
    out_item_t want;
    out_item_t got;
    bit        loud;
    bit        bad;
    if (rst_ni && out_if.valid && out_if.ready) begin
      got = out_if.payload;
      kind_seen[got.kind]++;
      if (got.kind == KindIssue && got.target <= TargetBus) target_seen[got.target]++;
      if (got.kind == KindDone && got.error == ErrMisaligned) misaligned_seen++;
      if (got.kind == KindDone && got.error == ErrBus) bus_err_seen++;
      if (pending_results.size() == 0) begin
        fault_count++;
        if (fault_count <= 10) $display("result beat with nothing expected, kind %0d", got.kind);
      end else begin
        want = pending_results.pop_front();
        loud = fault_count < 10;
        if (loud && want !== got) $display("mismatch at cycle %0d:", cycle_count);
        bad = 1'b0;
        bad |= field_diff("kind", 32'(want.kind), 32'(got.kind), loud);
        bad |= field_diff("target", 32'(want.target), 32'(got.target), loud);
        bad |= field_diff("mem_addr", want.mem_addr, got.mem_addr, loud);
        bad |= field_diff("mem_write", 32'(want.mem_write), 32'(got.mem_write), loud);
        bad |= field_diff("lane_strobe", 32'(want.lane_strobe), 32'(got.lane_strobe), loud);
        bad |= field_diff("write_lane", want.write_lane, got.write_lane, loud);
        bad |= field_diff("done_tag", 32'(want.done_tag), 32'(got.done_tag), loud);
        bad |= field_diff("done_dest_reg", 32'(want.done_dest_reg), 32'(got.done_dest_reg),
                          loud);
        bad |= field_diff("write_back", 32'(want.write_back), 32'(got.write_back), loud);
        bad |= field_diff("load_result", want.load_result, got.load_result, loud);
        bad |= field_diff("error", 32'(want.error), 32'(got.error), loud);
        bad |= field_diff("bad_addr", want.bad_addr, got.bad_addr, loud);
        if (bad) fault_count++;
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count == CycleLimit) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
               pending_results.size());
      $display("FAIL load_store_unit_lane_align");
      $finish;
    end
  end

  initial begin : sink_hold_ctl
    sink_hold <= 1'b0;
    forever begin
      @(hold_sink_ev);
      sink_hold <= 1'b1;
      repeat (SinkHoldCycles) @(posedge clk_i);
      sink_hold <= 1'b0;
    end
  end

  initial begin : sink_side
    int unsigned stall;
    out_if.ready <= 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      stall = rx_stalls ? $urandom_range(0, MaxGap) : 0;
      if (stall != 0 || sink_hold) out_if.ready <= 1'b0;
      repeat (stall) @(posedge clk_i);
      while (sink_hold) @(posedge clk_i);
      out_if.ready <= 1'b1;
      @(posedge clk_i);
      while (!out_if.valid && !sink_hold) @(posedge clk_i);
    end
  end

  initial begin
    rst_ni <= 1'b0;
    in_if.valid <= 1'b0;
    in_if.payload <= '0;
    cfg_we_i <= 1'b0;
    cfg_idx_i <= CfgDataBase;
    cfg_wdata_i <= '0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    test_regions();
    test_backpressure();
    test_random();

    wait_idle();
    repeat (10) @(posedge clk_i);
    $display("%0d input beats over %0d region settings: %0d issued, %0d completed, %0d refused, %0d dropped",
             beats_sent, region_settings, kind_seen[KindIssue], kind_seen[KindDone],
             kind_seen[KindBusy], kind_seen[KindDrop]);
    $display("issues to data/instr/bus %0d/%0d/%0d, misaligned %0d, bus errors %0d",
             target_seen[TargetData], target_seen[TargetInstr], target_seen[TargetBus],
             misaligned_seen, bus_err_seen);
    if (fault_count == 0 && pending_results.size() == 0) begin
      $display("PASS load_store_unit_lane_align");
    end else begin
      $display("%0d mismatches, %0d results never arrived", fault_count,
               pending_results.size());
      $display("FAIL load_store_unit_lane_align");
    end
    $finish;
  end

endmodule
